// ----- sv/fpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsc_pkg: shared constants and types for the fixed-point sine/cosine unit
// Holds the rounded pi constants, the reciprocal for the 2*pi wrap and the
// datapath widths used by the top level and the divider.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    localparam int FRAC_BITS = 16;

    // Exact seeds: pi * 2^60, and pi * 2^30 split into integer and fraction
    localparam logic [63:0] PI_SEED60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_SEED30_INT = 64'h00000000C90FDAA2;
    localparam logic [63:0] PI_SEED30_FRC = 64'h000000002168C234;

    localparam logic [63:0] PI_FIX64 =
        (PI_SEED60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] HALF_PI_FIX64 =
        (PI_SEED60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam logic [63:0] PI_SQ_RAW64 =
        PI_SEED30_INT * PI_SEED30_INT + ((PI_SEED30_INT * PI_SEED30_FRC) >> 31);
    localparam logic [63:0] PI_SQ_FIX64 =
        (PI_SQ_RAW64 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] TWO_PI_FIX64 = PI_FIX64 << 1;

    // Wrap reciprocal: floor(2^RECIP_SHIFT / (2*pi)), one correction step after
    localparam int RECIP_SHIFT = 48;
    localparam logic [63:0] RECIP64 = (64'd1 << RECIP_SHIFT) / TWO_PI_FIX64;

    // Datapath widths
    localparam int ANGLE_W = 31;  // input angle
    localparam int X_W     = 32;  // shifted angle and wrap operand
    localparam int RECIP_W = 30;  // reciprocal
    localparam int WQ_W    = 14;  // wrap quotient
    localparam int WR_W    = 20;  // wrap remainder, below twice 2*pi
    localparam int U_W     = 18;  // reduced angle 0..pi
    localparam int R1_W    = 18;  // u*(pi-u) rescaled
    localparam int DEN_W   = 22;  // 5*pi^2 - 4*r1
    localparam int NUM_W   = 38;  // 16*r1*one
    localparam int Q_W     = 17;  // quotient, at most one
    localparam int VAL_W   = 18;  // result value

    localparam logic [WR_W-1:0]  TWO_PI  = TWO_PI_FIX64[WR_W-1:0];
    localparam logic [U_W-1:0]   PI_FIX  = PI_FIX64[U_W-1:0];
    localparam logic [X_W-1:0]   HALF_PI = HALF_PI_FIX64[X_W-1:0];
    localparam logic [X_W-1:0]   PI_X    = PI_FIX64[X_W-1:0];
    localparam logic [DEN_W-1:0] PI_SQ5  = DEN_W'(PI_SQ_FIX64 * 64'd5);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
    localparam logic [Q_W-1:0]   ONE     = Q_W'(64'd1 << FRAC_BITS);

    // Sideband that travels with an item through the divider
    typedef struct packed {
        logic valid;
        logic neg;
    } tag_t;

endpackage

// ----- sv/fpsc_div.sv -----
// ----------------------------------------------------------------------------
// fpsc_div: pipelined restoring divider
// One quotient bit per stage, Q_W stages; the whole pipe advances on en.
// ----------------------------------------------------------------------------
module fpsc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  fpsc_pkg::tag_t                in_tag,
    input  logic [fpsc_pkg::NUM_W-1:0]    num,
    input  logic [fpsc_pkg::DEN_W-1:0]    den,
    output fpsc_pkg::tag_t                out_tag,
    output logic [fpsc_pkg::Q_W-1:0]      quo
);

    localparam int QW = fpsc_pkg::Q_W;
    localparam int DW = fpsc_pkg::DEN_W;
    localparam int NW = fpsc_pkg::NUM_W;

    // Index 0 is the stage input, index k the output of step k
    logic           valid_reg [QW+1];
    logic           neg_reg   [QW+1];
    logic [DW-1:0]  rem_reg   [QW+1];
    logic [QW-1:0]  low_reg   [QW+1];
    logic [QW-1:0]  q_reg     [QW+1];
    logic [DW-1:0]  den_reg   [QW+1];

    // Upper numerator bits are known to be below den (quotient fits QW bits)
    assign valid_reg[0] = in_tag.valid;
    assign neg_reg[0]   = in_tag.neg;
    assign rem_reg[0]   = DW'(num[NW-1:QW]);
    assign low_reg[0]   = num[QW-1:0];
    assign q_reg[0]     = '0;
    assign den_reg[0]   = den;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;

        always_comb begin
            trial    = {rem_reg[k], low_reg[k][QW-1]};
            ge       = (trial >= {1'b0, den_reg[k]});
            diff     = trial - {1'b0, den_reg[k]};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[k+1] <= neg_reg[k];
                rem_reg[k+1] <= rem_next;
                low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][QW-2:0], ge};
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign out_tag.valid = valid_reg[QW];
    assign out_tag.neg   = neg_reg[QW];
    assign quo           = q_reg[QW];

endmodule

// ----- sv/fixed_point_sin_cos.sv -----
// ----------------------------------------------------------------------------
// fixed_point_sin_cos: Bhaskara sine/cosine in fixed point
// Throughput: one angle per cycle; the whole pipe holds while the output
// register waits on m_tready, and s_tready follows that same enable.
// The 17-stage quotient pipeline sets the depth.
// Reset (aresetn low, synchronous) drops every valid bit; data regs keep.
// ----------------------------------------------------------------------------
module fixed_point_sin_cos (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] angle
    input  logic        s_tuser,   // [0] req_type: 0 cosine, 1 sine
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [17:0] value
);

    localparam int X_W   = fpsc_pkg::X_W;
    localparam int WQ_W  = fpsc_pkg::WQ_W;
    localparam int WR_W  = fpsc_pkg::WR_W;
    localparam int U_W   = fpsc_pkg::U_W;
    localparam int R1_W  = fpsc_pkg::R1_W;
    localparam int DEN_W = fpsc_pkg::DEN_W;
    localparam int NUM_W = fpsc_pkg::NUM_W;
    localparam int Q_W   = fpsc_pkg::Q_W;
    localparam int VAL_W = fpsc_pkg::VAL_W;
    localparam int FB    = fpsc_pkg::FRAC_BITS;
    localparam int RS    = fpsc_pkg::RECIP_SHIFT;

    // Global advance: move everything whenever the output slot is free or drains
    logic en;
    logic out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Valid bits for stages 1..7
    logic [6:0] v_reg;

    // Stage 1: sign-extend the angle, subtract pi/2 for a sine request
    logic signed [X_W-1:0] x_reg;
    logic signed [X_W-1:0] x_next;
    always_comb begin
        x_next = X_W'(signed'(s_tdata[fpsc_pkg::ANGLE_W-1:0]));
        if (s_tuser) begin
            x_next = x_next - signed'(fpsc_pkg::HALF_PI);
        end
    end

    // Stage 2: n = |x| + pi/2 + pi, always positive
    logic [X_W-1:0] n_reg;
    logic [X_W-1:0] n_next;
    logic [X_W-1:0] ax;
    always_comb begin
        ax     = x_reg[X_W-1] ? X_W'(-x_reg) : X_W'(x_reg);
        n_next = ax + fpsc_pkg::HALF_PI + fpsc_pkg::PI_X;
    end

    // Stage 3: estimate n / (2*pi) by reciprocal multiply; may be low by one
    logic [X_W-1:0]  n3_reg;
    logic [WQ_W-1:0] wq_reg;
    logic [X_W+fpsc_pkg::RECIP_W-1:0] wprod;
    assign wprod = n_reg * fpsc_pkg::RECIP;

    // Stage 4: remainder against the estimate, below twice 2*pi
    logic [WR_W-1:0] wr_reg;
    logic [X_W-1:0]  wsub;
    logic [X_W-1:0]  wr_full;
    always_comb begin
        wsub    = X_W'(wq_reg) * X_W'(fpsc_pkg::TWO_PI);
        wr_full = n3_reg - wsub;
    end

    // Stage 5: finish the wrap, w = r - pi in [-pi, pi); keep |w| and its sign
    logic [U_W-1:0] u_reg;
    logic           neg5_reg;
    logic [WR_W-1:0] wr_fix;
    logic signed [WR_W:0] w_s;
    always_comb begin
        wr_fix = (wr_reg >= fpsc_pkg::TWO_PI) ? wr_reg - fpsc_pkg::TWO_PI : wr_reg;
        w_s    = signed'({1'b0, wr_fix}) - signed'((WR_W+1)'(fpsc_pkg::PI_FIX));
    end

    // Stage 6: r1 = u*(pi-u) / one, truncated
    logic [R1_W-1:0] r1_reg;
    logic            neg6_reg;
    logic [2*U_W-1:0] uprod;
    assign uprod = u_reg * (fpsc_pkg::PI_FIX - u_reg);

    // Stage 7: numerator 16*r1*one and denominator 5*pi^2 - 4*r1
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            n_reg    <= n_next;
            n3_reg   <= n_reg;
            wq_reg   <= wprod[RS+WQ_W-1:RS];
            wr_reg   <= wr_full[WR_W-1:0];
            u_reg    <= w_s[WR_W] ? U_W'(-w_s) : U_W'(w_s);
            neg5_reg <= w_s[WR_W];
            r1_reg   <= uprod[FB+R1_W-1:FB];
            neg6_reg <= neg5_reg;
            num_reg  <= {r1_reg, (NUM_W-R1_W)'(0)};
            den_reg  <= fpsc_pkg::PI_SQ5 - {r1_reg, 2'b00};
            neg7_reg <= neg6_reg;
        end
    end

    // Quotient pipeline
    fpsc_pkg::tag_t div_in_tag;
    fpsc_pkg::tag_t div_out_tag;
    logic [Q_W-1:0] div_q;

    assign div_in_tag.valid = v_reg[6];
    assign div_in_tag.neg   = neg7_reg;

    fpsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (div_in_tag),
        .num     (num_reg),
        .den     (den_reg),
        .out_tag (div_out_tag),
        .quo     (div_q)
    );

    // Output: clamp to one, restore the sign from the odd symmetry
    logic [Q_W-1:0]   qc;
    logic [VAL_W-1:0] val_next;
    always_comb begin
        qc       = (div_q > fpsc_pkg::ONE) ? fpsc_pkg::ONE : div_q;
        val_next = div_out_tag.neg ? VAL_W'(-{1'b0, qc}) : VAL_W'({1'b0, qc});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= div_out_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_value_reg <= val_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(24-VAL_W)'(0), out_value_reg};

`ifndef ASSERT_OFF
    // Wrap remainder stays below twice 2*pi, so one correction suffices
    a_wrap_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[3] |-> (wr_reg < (fpsc_pkg::TWO_PI << 1)))
        else $error("wrap remainder out of range");

    // Reduced angle never exceeds pi
    a_u_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[4] |-> (u_reg <= fpsc_pkg::PI_FIX))
        else $error("reduced angle above pi");

    // Denominator stays positive for every reduced angle
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[6] |-> (den_reg != '0))
        else $error("zero denominator");

    // Magnitude of a delivered result never exceeds one
    a_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        div_out_tag.valid |-> (div_q <= fpsc_pkg::ONE))
        else $error("quotient above one");
`endif

endmodule

// ----- dv/fixed_point_sin_cos_test.sv -----
// ----------------------------------------------------------------------------
// fixed_point_sin_cos_test: self-checking bench for the sine/cosine unit
// Drives angles with a cosine or sine request over the s_ stream, predicts
// each result in a local Bhaskara model and checks every m_ transfer in order.
// Runs through phases with and without random source gaps and sink stalls.
// ----------------------------------------------------------------------------
class trig_scoreboard;
    logic [17:0] pending[$];
    int          errors;
    longint      pi_v, half_pi_v, pi_sq_v;

    function new();
        logic [63:0] seed60, a, fr, sq;
        seed60 = 64'h3243F6A8885A308D;
        a = 64'hC90FDAA2;
        fr = 64'h2168C234;
        pi_v = longint'((seed60 + (64'd1 << 43)) >> 44);
        half_pi_v = longint'((seed60 + (64'd1 << 44)) >> 45);
        sq = a * a + ((a * fr) >> 31);
        pi_sq_v = longint'((sq + (64'd1 << 43)) >> 44);
        errors = 0;
    endfunction

    // Rational form, valid for 0 <= u <= pi
    function longint rational_sin(longint u);
        longint r1, den, q;
        r1 = (u * (pi_v - u)) / 65536;
        den = 5 * pi_sq_v - 4 * r1;
        if (den <= 0) return 65536;
        q = (16 * r1 * 65536) / den;
        if (q > 65536) q = 65536;
        return q;
    endfunction

    function logic [17:0] trig_value(logic req_sine, logic [30:0] angle);
        longint x, w;
        x = longint'($signed(angle));
        if (req_sine) x -= half_pi_v;
        if (x < 0) x = -x;
        x += half_pi_v;
        w = ((x + pi_v) % (2 * pi_v)) - pi_v;
        if (w < 0) return 18'(-rational_sin(-w));
        return 18'(rational_sin(w));
    endfunction

    function void note_angle(logic req_sine, logic [30:0] angle);
        pending.push_back(trig_value(req_sine, angle));
    endfunction

    function void check_value(logic [17:0] got);
        if (pending.size() == 0) begin
            $error("unexpected result: value %0d", $signed(got));
            errors++;
            return;
        end
        if (pending[0] !== got) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(pending[0]), $signed(got));
            errors++;
        end
        void'(pending.pop_front());
    endfunction
endclass

module fixed_point_sin_cos_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Percent chance per cycle of a source gap and of a sink stall
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int cycles = 0;

    trig_scoreboard board = new();

    fixed_point_sin_cos u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [30:0] angle
        .s_tuser (s_tuser),   // [0] req_type
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // [17:0] value
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Check each result transfer at the rising edge; bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready)
            board.check_value(m_tdata[17:0]);
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Randomize the sink stall at each falling edge
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= snk_stall_pct);
    end

    // Present one angle, hold it until the transfer, note it on acceptance
    task automatic send_angle(logic req_sine, logic [30:0] angle);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, angle};
        s_tuser <= req_sine;
        do @(posedge aclk); while (!s_tready);
        board.note_angle(req_sine, angle);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    // Mostly within about -2*pi..2*pi, sometimes anywhere in the field
    function automatic logic [30:0] random_angle();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'($signed(18'($urandom)));
            default: return 31'(int'($urandom_range(822000)) - 411000);
        endcase
    endfunction

    initial begin
        logic [30:0] edges[$];
        edges = '{31'h0, 31'h1, 31'h7FFFFFFF, 31'h3FFFFFFF, 31'h40000000,
                  31'd102944, 31'd205887, 31'd411775, 31'h7FFCDBC1 /* -pi */,
                  31'd51472, 31'h7FFF36F0, 31'h55555555};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Extremes of the angle, both request types
        foreach (edges[i]) begin
            send_angle(1'b0, edges[i]);
            send_angle(1'b1, edges[i]);
        end
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 73 : 27) : 0;
            snk_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 73 : 27) : 0;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                send_angle(1'($urandom), random_angle());
            // Hold the source until the pipe is empty
            drain();
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (40) @(negedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- fixed_point_sin_cos.f -----
sv/fpsc_pkg.sv
sv/fpsc_div.sv
sv/fixed_point_sin_cos.sv
dv/fixed_point_sin_cos_test.sv
